FILE: rtl/core/mmx_pkg.sv
package mmx_pkg;

    localparam int CHANNELS  = 8;
    localparam int CODE_BITS = 12;
    localparam int COUNT_W   = 16;
    localparam int CH_W      = 3;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 1'b1;

    localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] PERIOD_LENGTH_RST = 16'd10;
    localparam logic [COUNT_W-1:0] COUNT_TOP         = {COUNT_W{1'b1}};

    localparam logic signed [CODE_BITS-1:0] CODE_TOP    = {1'b0, {(CODE_BITS-1){1'b1}}};
    localparam logic signed [CODE_BITS-1:0] CODE_BOTTOM = {1'b1, {(CODE_BITS-1){1'b0}}};

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    typedef logic [CHANNELS-1:0][CODE_BITS-1:0] code_vec_t;
    typedef logic [CHANNELS-1:0][WORD_W-1:0] word_vec_t;

    typedef struct packed {
        code_vec_t            codes;
        code_vec_t            mins;
        code_vec_t            maxs;
        logic [COUNT_W-1:0]   period_count;
        logic                 period_done;
        logic                 window_done;
    } frame_t;

endpackage

FILE: rtl/core/mmx_front.sv
module mmx_front
    import mmx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  word_vec_t            words,
    output frame_t               frame
);

    logic [COUNT_W-1:0] window_length_reg;
    logic [COUNT_W-1:0] period_length_reg;
    logic [COUNT_W-1:0] window_frames_reg;
    logic [COUNT_W-1:0] window_frames_next;
    logic [COUNT_W-1:0] period_frames_reg;
    logic [COUNT_W-1:0] period_frames_next;
    code_vec_t          min_reg;
    code_vec_t          min_next;
    code_vec_t          max_reg;
    code_vec_t          max_next;
    logic [COUNT_W-1:0] window_inc;
    logic [COUNT_W-1:0] period_inc;
    logic               win_done;
    logic               per_done;

    always_comb
    begin
        logic signed [CODE_BITS-1:0] c;
        logic signed [CODE_BITS-1:0] lo;
        logic signed [CODE_BITS-1:0] hi;
        window_inc = (window_frames_reg == COUNT_TOP) ? COUNT_TOP : window_frames_reg + 1'b1;
        period_inc = (period_frames_reg == COUNT_TOP) ? COUNT_TOP : period_frames_reg + 1'b1;
        win_done   = window_inc >= window_length_reg;
        per_done   = period_inc >= period_length_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            c  = $signed(words[i][CODE_BITS:1]);
            lo = $signed(min_reg[i]);
            hi = $signed(max_reg[i]);
            frame.codes[i] = c;
            frame.mins[i]  = (c < lo) ? c : lo;
            frame.maxs[i]  = (c > hi) ? c : hi;
            min_next[i]    = win_done ? c : frame.mins[i];
            max_next[i]    = win_done ? c : frame.maxs[i];
        end
        frame.period_count = period_inc;
        frame.period_done  = per_done;
        frame.window_done  = win_done;
        window_frames_next = win_done ? '0 : window_inc;
        period_frames_next = per_done ? '0 : period_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            period_length_reg <= PERIOD_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                REG_PERIOD_LENGTH: period_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_frames_reg <= '0;
            period_frames_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                min_reg[i] <= CODE_TOP;
                max_reg[i] <= CODE_BOTTOM;
            end
        end
        else if (accept)
        begin
            window_frames_reg <= window_frames_next;
            period_frames_reg <= period_frames_next;
            min_reg           <= min_next;
            max_reg           <= max_next;
        end
    end

endmodule

FILE: rtl/core/mmx_queue.sv
module mmx_queue
    import mmx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output frame_t pop_data,
    output logic   empty
);

    frame_t      mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/mmx_back.sv
module mmx_back
    import mmx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  frame_t                      q_data,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [CH_W-1:0]             channel,
    output logic signed [CODE_BITS-1:0] sample_code,
    output logic signed [CODE_BITS-1:0] window_min,
    output logic signed [CODE_BITS-1:0] window_max,
    output logic                        last,
    output logic [COUNT_W-1:0]          period_count,
    output logic                        period_done,
    output logic                        window_done
);

    frame_t          cur_reg;
    logic            valid_reg;
    logic [CH_W-1:0] idx_reg;
    logic            advance;
    logic            at_last;

    assign at_last = idx_reg == LAST_CH;
    assign advance = !valid_reg || (pop && at_last);
    assign q_pop   = advance && !q_empty;
    assign empty   = !valid_reg;

    assign channel      = idx_reg;
    assign sample_code  = cur_reg.codes[idx_reg];
    assign window_min   = cur_reg.mins[idx_reg];
    assign window_max   = cur_reg.maxs[idx_reg];
    assign last         = at_last;
    assign period_count = at_last ? cur_reg.period_count : '0;
    assign period_done  = at_last && cur_reg.period_done;
    assign window_done  = at_last && cur_reg.window_done;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

FILE: rtl/core/multichannel_windowed_min_max_unit.sv
// A taken frame is written into the frame queue and then into the result register that
// drives the ports. The result serializer emits one channel per cycle while pop is held;
// a two-entry frame queue lets the input take frames ahead of it.
// Reset: asynchronous, active low; min and max start at the code extremes, counters at zero,
// window length 1000 and period length 10.
module multichannel_windowed_min_max_unit
    import mmx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [WORD_W-1:0]           word_ch0,
    input  logic [WORD_W-1:0]           word_ch1,
    input  logic [WORD_W-1:0]           word_ch2,
    input  logic [WORD_W-1:0]           word_ch3,
    input  logic [WORD_W-1:0]           word_ch4,
    input  logic [WORD_W-1:0]           word_ch5,
    input  logic [WORD_W-1:0]           word_ch6,
    input  logic [WORD_W-1:0]           word_ch7,
    output logic                        empty,
    input  logic                        pop,
    output logic [CH_W-1:0]             channel,
    output logic signed [CODE_BITS-1:0] sample_code,
    output logic signed [CODE_BITS-1:0] window_min,
    output logic signed [CODE_BITS-1:0] window_max,
    output logic                        last,
    output logic [COUNT_W-1:0]          period_count,
    output logic                        period_done,
    output logic                        window_done
);

    logic [7:0][WORD_W-1:0] all_words;
    word_vec_t              words;
    frame_t                 front_frame;
    frame_t                 q_data;
    logic                   accept;
    logic                   q_empty;
    logic                   q_pop;

    assign all_words = {word_ch7, word_ch6, word_ch5, word_ch4,
                        word_ch3, word_ch2, word_ch1, word_ch0};

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            words[i] = all_words[i];
        end
    end

    assign accept = push && !full;

    mmx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .words     (words),
        .frame     (front_frame)
    );

    mmx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_frame),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    mmx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .channel      (channel),
        .sample_code  (sample_code),
        .window_min   (window_min),
        .window_max   (window_max),
        .last         (last),
        .period_count (period_count),
        .period_done  (period_done),
        .window_done  (window_done)
    );

endmodule

FILE: verif/min_max_checker.sv
`timescale 1ns / 100ps

module min_max_checker
    import mmx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        push,
    input  logic                        full,
    input  logic [WORD_W-1:0]           word_ch0,
    input  logic [WORD_W-1:0]           word_ch1,
    input  logic [WORD_W-1:0]           word_ch2,
    input  logic [WORD_W-1:0]           word_ch3,
    input  logic [WORD_W-1:0]           word_ch4,
    input  logic [WORD_W-1:0]           word_ch5,
    input  logic [WORD_W-1:0]           word_ch6,
    input  logic [WORD_W-1:0]           word_ch7,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [CH_W-1:0]             channel,
    input  logic signed [CODE_BITS-1:0] sample_code,
    input  logic signed [CODE_BITS-1:0] window_min,
    input  logic signed [CODE_BITS-1:0] window_max,
    input  logic                        last,
    input  logic [COUNT_W-1:0]          period_count,
    input  logic                        period_done,
    input  logic                        window_done,
    output int                          mismatches,
    output int                          results_left,
    output int                          results_checked,
    output int                          windows_closed,
    output int                          periods_closed
);

    typedef struct {
        logic [CH_W-1:0]             chan;
        logic signed [CODE_BITS-1:0] code;
        logic signed [CODE_BITS-1:0] lo;
        logic signed [CODE_BITS-1:0] hi;
        logic                        is_last;
        logic [COUNT_W-1:0]          count;
        logic                        per_flag;
        logic                        win_flag;
    } channel_result_t;

    channel_result_t             pending_results[$];
    logic signed [CODE_BITS-1:0] run_min [CHANNELS];
    logic signed [CODE_BITS-1:0] run_max [CHANNELS];
    logic [COUNT_W-1:0]          win_frames;
    logic [COUNT_W-1:0]          per_frames;
    logic [COUNT_W-1:0]          win_len;
    logic [COUNT_W-1:0]          per_len;

    task automatic track_frame(input word_vec_t words);
        logic signed [CODE_BITS-1:0] codes [CHANNELS];
        logic                        win_close;
        logic                        per_close;
        channel_result_t             r;
        if (per_frames != COUNT_TOP)
            per_frames++;
        if (win_frames != COUNT_TOP)
            win_frames++;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            codes[ch] = words[ch][CODE_BITS:1];
            if (codes[ch] < run_min[ch])
                run_min[ch] = codes[ch];
            if (codes[ch] > run_max[ch])
                run_max[ch] = codes[ch];
        end
        win_close = (win_frames >= win_len);
        per_close = (per_frames >= per_len);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            r.chan     = CH_W'(ch);
            r.code     = codes[ch];
            r.lo       = run_min[ch];
            r.hi       = run_max[ch];
            r.is_last  = (r.chan == LAST_CH);
            r.count    = r.is_last ? per_frames : '0;
            r.per_flag = r.is_last && per_close;
            r.win_flag = r.is_last && win_close;
            pending_results.push_back(r);
        end
        if (win_close)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                run_min[ch] = codes[ch];
                run_max[ch] = codes[ch];
            end
            win_frames = '0;
        end
        if (per_close)
            per_frames = '0;
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        channel_result_t r;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: result for channel %0d with no frame pending, expected none, actual %0d",
                     $time, channel, sample_code);
            mismatches++;
        end
        else
        begin
            r = pending_results.pop_front();
            compare_field("channel", int'(r.chan), int'(channel));
            compare_field("sample_code", int'(r.code), int'(sample_code));
            compare_field("window_min", int'(r.lo), int'(window_min));
            compare_field("window_max", int'(r.hi), int'(window_max));
            compare_field("last", int'(r.is_last), int'(last));
            compare_field("period_count", int'(r.count), int'(period_count));
            compare_field("period_done", int'(r.per_flag), int'(period_done));
            compare_field("window_done", int'(r.win_flag), int'(window_done));
            results_checked++;
        end
        if (last && window_done)
            windows_closed++;
        if (last && period_done)
            periods_closed++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                run_min[ch] = CODE_TOP;
                run_max[ch] = CODE_BOTTOM;
            end
            win_frames = '0;
            per_frames = '0;
            win_len    = WINDOW_LENGTH_RST;
            per_len    = PERIOD_LENGTH_RST;
            pending_results.delete();
            mismatches      = 0;
            results_checked = 0;
            windows_closed  = 0;
            periods_closed  = 0;
            results_left   <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: win_len = cfg_data;
                    REG_PERIOD_LENGTH: per_len = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
                check_result();
            if (push && !full)
                track_frame({word_ch7, word_ch6, word_ch5, word_ch4,
                             word_ch3, word_ch2, word_ch1, word_ch0});
            results_left <= pending_results.size();
        end
    end

endmodule

FILE: verif/tb_multichannel_windowed_min_max_unit.sv
`timescale 1ns / 100ps

module tb_multichannel_windowed_min_max_unit;
    import mmx_pkg::*;

    localparam int STALL_LIMIT    = 3000;
    localparam int LONG_HOLD      = 80;
    localparam int HOLD_AT_RESULT = 350;
    localparam int SETTLE_CYCLES  = 8;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        push;
    logic                        full;
    logic [WORD_W-1:0]           word_ch0;
    logic [WORD_W-1:0]           word_ch1;
    logic [WORD_W-1:0]           word_ch2;
    logic [WORD_W-1:0]           word_ch3;
    logic [WORD_W-1:0]           word_ch4;
    logic [WORD_W-1:0]           word_ch5;
    logic [WORD_W-1:0]           word_ch6;
    logic [WORD_W-1:0]           word_ch7;
    logic                        empty;
    logic                        pop;
    logic [CH_W-1:0]             channel;
    logic signed [CODE_BITS-1:0] sample_code;
    logic signed [CODE_BITS-1:0] window_min;
    logic signed [CODE_BITS-1:0] window_max;
    logic                        last;
    logic [COUNT_W-1:0]          period_count;
    logic                        period_done;
    logic                        window_done;

    int mismatches;
    int results_left;
    int results_checked;
    int windows_closed;
    int periods_closed;
    int frames_sent;
    int settings_used;
    int quiet_cycles;

    multichannel_windowed_min_max_unit u_dut (.*);

    min_max_checker u_check (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: nothing accepted for %0d cycles.", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic word_vec_t directed_frame(input int k);
        word_vec_t w;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            case (k)
                0: w[ch] = 16'h0000;
                1: w[ch] = 16'hFFFF;
                2: w[ch] = 16'h0FFE;
                3: w[ch] = 16'h1000;
                4: w[ch] = 16'hF001;
                5: w[ch] = 16'h0FFF;
                6: w[ch] = 16'hF000;
                default: w[ch] = 16'h0001 << ((k - 7 + ch) % 16);
            endcase
        end
        return w;
    endfunction

    function automatic word_vec_t random_frame();
        word_vec_t            w;
        int                   pick;
        logic [CODE_BITS-1:0] c;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
            begin
                c = $urandom_range(0, 1) ? CODE_TOP : CODE_BOTTOM;
                w[ch] = {3'($urandom), c, 1'($urandom)};
            end
            else if (pick == 1)
            begin
                c = CODE_BITS'(int'($urandom_range(0, 16)) - 8);
                w[ch] = {3'($urandom), c, 1'($urandom)};
            end
            else
                w[ch] = 16'($urandom);
        end
        return w;
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (results_left != 0);
    endtask

    task automatic send_frame(input word_vec_t w, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch0 <= w[0];
        word_ch1 <= w[1];
        word_ch2 <= w[2];
        word_ch3 <= w[3];
        word_ch4 <= w[4];
        word_ch5 <= w[5];
        word_ch6 <= w[6];
        word_ch7 <= w[7];
        push     <= 1'b1;
        do
            @(posedge clk);
        while (full);
        frames_sent++;
    endtask

    task automatic run_random(input int count, input bit steady);
        for (int i = 0; i < count; i++)
            send_frame(random_frame(), steady);
        push <= 1'b0;
    endtask

    task automatic apply_lengths(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] per);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= win;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_index <= REG_PERIOD_LENGTH;
        cfg_data  <= per;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : receiver
        int  gap;
        int  taken;
        bit  steady;
        taken  = 0;
        steady = 1'b0;
        pop   <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            gap = steady ? 0 : $urandom_range(0, 4);
            if (taken == HOLD_AT_RESULT)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            taken++;
        end
    end

    initial
    begin : stimulus
        frames_sent   = 0;
        settings_used = 1;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= '0;
        push      <= 1'b0;
        word_ch0  <= '0;
        word_ch1  <= '0;
        word_ch2  <= '0;
        word_ch3  <= '0;
        word_ch4  <= '0;
        word_ch5  <= '0;
        word_ch6  <= '0;
        word_ch7  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 23; k++)
            send_frame(directed_frame(k), 1'b0);
        push <= 1'b0;

        // Both lengths drop below the running counts, so both close on the next frame.
        apply_lengths(16'd3, 16'd1);
        run_random(60, 1'b0);
        apply_lengths(16'd0, 16'd0);
        run_random(40, 1'b1);
        apply_lengths(16'hFFFF, 16'hFFFF);
        run_random(50, 1'b0);
        apply_lengths(16'd1, 16'd2);
        run_random(20, 1'b1);
        wait_drained();
        run_random(20, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            apply_lengths((i == 0) ? 16'($urandom) : 16'($urandom_range(1, 30)),
                          16'($urandom_range(1, 30)));
            run_random(55, 1'b0);
        end
        apply_lengths(16'd2, 16'd7);
        run_random(30, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d frames under %0d length settings, with a long result stall and a drain pause.",
                 frames_sent, settings_used);
        $display("Checked %0d channel results; saw %0d window closes and %0d period closes.",
                 results_checked, windows_closed, periods_closed);
        if (mismatches == 0 && results_left == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
